// ----- hw/rtl/qpc_pkg.sv -----
// shared types, codes and decode table for the quadrature position counter
package qpc_pkg;

	// operation codes of an input item
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_LOAD   = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_UPPER_LIMIT = 2'd0;
	localparam logic [1:0] REG_LOWER_LIMIT = 2'd1;
	localparam logic [1:0] REG_STEP_SIZE   = 2'd2;

	// field widths
	localparam int PosW  = 15;
	localparam int DposW = 16;
	localparam int StepW = 16;

	// two-bit gray code values of the phase pair {a, b}
	localparam logic [1:0] PH_00 = 2'd0;
	localparam logic [1:0] PH_01 = 2'd1;
	localparam logic [1:0] PH_10 = 2'd2;
	localparam logic [1:0] PH_11 = 2'd3;

	typedef enum logic [1:0] {
		MV_NONE,
		MV_FWD,
		MV_REV
	} move_t;

	typedef struct packed {
		logic [PosW-1:0]  upper_limit;
		logic [PosW-1:0]  lower_limit;
		logic [StepW-1:0] step_size;
	} qpc_cfg_t;

	// forward sequence 0 -> 2 -> 3 -> 1 -> 0, reverse is the opposite way
	function automatic move_t decode_move(input logic [1:0] prev, input logic [1:0] curr);
		move_t mv;
		mv = MV_NONE;
		case ({prev, curr})
			{PH_00, PH_10}, {PH_10, PH_11}, {PH_11, PH_01}, {PH_01, PH_00}: mv = MV_FWD;
			{PH_00, PH_01}, {PH_01, PH_11}, {PH_11, PH_10}, {PH_10, PH_00}: mv = MV_REV;
			default: mv = MV_NONE;
		endcase
		return mv;
	endfunction

endpackage

// ----- hw/rtl/quadrature_position_counter_unit.sv -----
// top level of the quadrature position counter
//
// Usage: each input transfer carries one sample of the encoder phases, or a
// load of a new position when operation is high. Every input transfer
// produces exactly one output transfer carrying the position in whole
// detents (internal half-detent count shifted right by one).
// The result of an accepted item goes into the result register, or into the
// skid entry while a result waits. Throughput is one item per clock while
// in_stall is low; the position update is a single add or subtract with a
// compare against the doubled limit, done in the cycle of the transfer.
// An output register with a one-entry skid stage sits on the result side, so
// an item is still taken while one result waits. in_stall is high whenever
// the skid entry, and so both entries, are full.
// The limits and step size are written through wr_en / wr_index / wr_data;
// the user must write them only while the block is idle, which the block
// does not enforce itself; writes to unused indexes are dropped. Reset clears
// the phase history and the position to zero, sets the upper limit to 32767,
// the lower limit to 0 and the step to 1, and empties both result entries.
module quadrature_position_counter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          wr_en,
	input  logic [1:0]                    wr_index,
	input  logic [qpc_pkg::StepW-1:0]     wr_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic                          phase_a,
	input  logic                          phase_b,
	input  logic [qpc_pkg::PosW-1:0]      new_position,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [qpc_pkg::PosW-1:0]      position
);
	import qpc_pkg::*;

	qpc_cfg_t         cfg_q;
	logic [DposW-1:0] dpos_q;
	logic [1:0]       phases_q;
	logic [DposW-1:0] dpos_next;
	logic [1:0]       phases_next;

	logic             out_valid_q;
	logic [PosW-1:0]  out_pos_q;
	logic             skid_valid_q;
	logic [PosW-1:0]  skid_pos_q;

	logic             in_xfer;
	logic             out_xfer;

	assign in_stall  = skid_valid_q;
	assign in_xfer   = in_valid && !skid_valid_q;
	assign out_xfer  = out_valid_q && !out_stall;
	assign out_valid = out_valid_q;
	assign position  = out_pos_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper_limit <= {PosW{1'b1}};
			cfg_q.lower_limit <= '0;
			cfg_q.step_size   <= StepW'(1);
		end else if (wr_en) begin
			case (wr_index)
				REG_UPPER_LIMIT: cfg_q.upper_limit <= wr_data[PosW-1:0];
				REG_LOWER_LIMIT: cfg_q.lower_limit <= wr_data[PosW-1:0];
				REG_STEP_SIZE:   cfg_q.step_size   <= wr_data;
				default:         ;
			endcase
		end
	end

	// position update logic
	qpc_update u_update (
		.cfg          (cfg_q),
		.dpos         (dpos_q),
		.prev_phases  (phases_q),
		.operation    (operation),
		.phase_a      (phase_a),
		.phase_b      (phase_b),
		.new_position (new_position),
		.dpos_next    (dpos_next),
		.phases_next  (phases_next)
	);

	// decoder state, advanced on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpos_q   <= '0;
			phases_q <= '0;
		end else if (in_xfer) begin
			dpos_q   <= dpos_next;
			phases_q <= phases_next;
		end
	end

	// result register and skid entry control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_xfer || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_xfer;
			end
		end else if (in_xfer) begin
			skid_valid_q <= 1'b1;
		end
	end

	// result payloads
	always_ff @(posedge clk) begin
		if (out_xfer || !out_valid_q) begin
			if (skid_valid_q) begin
				out_pos_q <= skid_pos_q;
			end else if (in_xfer) begin
				out_pos_q <= dpos_next[DposW-1:1];
			end
		end else if (in_xfer) begin
			skid_pos_q <= dpos_next[DposW-1:1];
		end
	end

	// skid entry is only ever filled behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry full while result register empty");

	// the position moves only on an input transfer
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_xfer |=> $stable(dpos_q))
		else $error("position changed without an input transfer");

	// a drained skid entry moves into the result register
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_xfer) |=> (out_valid_q && out_pos_q == $past(skid_pos_q)))
		else $error("skid entry lost on drain");

	// a load leaves a whole-detent position
	a_load_even: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && operation == OP_LOAD) |=> (dpos_q[0] == 1'b0))
		else $error("load left an odd half-detent count");

endmodule

// ----- hw/rtl/qpc_update.sv -----
// next-state logic: gray decode and saturating step of the doubled position
module qpc_update (
	input  qpc_pkg::qpc_cfg_t          cfg,
	input  logic [qpc_pkg::DposW-1:0]  dpos,
	input  logic [1:0]                 prev_phases,
	input  logic                       operation,
	input  logic                       phase_a,
	input  logic                       phase_b,
	input  logic [qpc_pkg::PosW-1:0]   new_position,
	output logic [qpc_pkg::DposW-1:0]  dpos_next,
	output logic [1:0]                 phases_next
);
	import qpc_pkg::*;

	logic [1:0]       code;
	move_t            mv;
	logic [DposW-1:0] hi;
	logic [DposW-1:0] lo;
	logic [DposW:0]   sum;
	logic [DposW-1:0] gap;

	assign code = {phase_a, phase_b};
	assign mv   = decode_move(prev_phases, code);
	assign hi   = {cfg.upper_limit, 1'b0};
	assign lo   = {cfg.lower_limit, 1'b0};
	assign sum  = {1'b0, dpos} + {1'b0, cfg.step_size};
	assign gap  = dpos - lo;

	// load replaces the position, a sample steps it within the limits
	always_comb begin
		dpos_next   = dpos;
		phases_next = prev_phases;
		if (operation == OP_LOAD) begin
			dpos_next = {new_position, 1'b0};
		end else begin
			phases_next = code;
			if (mv == MV_FWD && dpos < hi) begin
				dpos_next = (sum > {1'b0, hi}) ? hi : sum[DposW-1:0];
			end else if (mv == MV_REV && dpos > lo) begin
				dpos_next = (gap > cfg.step_size) ? dpos - cfg.step_size : lo;
			end
		end
	end

endmodule
